FILE: rtl/multiturn_angle_velocity_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker assertion macros
// Property wrappers sampled on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTITURN_ANGLE_VELOCITY_TRACKER_TOP_ASSERT_SVH
`define MULTITURN_ANGLE_VELOCITY_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define MAVT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MAVT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mavt_pkg.sv
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker package
// Field widths, arithmetic constants, register indexes and shared types.
// ----------------------------------------------------------------------------
package mavt_pkg;

  localparam int RAW_W     = 12;
  localparam int TIMER_W   = 24;
  localparam int ANGLE_W   = 44;
  localparam int VEL_W     = 37;
  localparam int TURN_W    = 32;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam int COUNTS_PER_TURN  = 4096;
  localparam int TICKS_PER_SECOND = 9000000;

  localparam int MAG_W   = ANGLE_W;
  localparam int HALF_W  = MAG_W / 2;
  localparam int TPS_W   = 24;
  localparam int PROD_W  = MAG_W + TPS_W;
  localparam int PPROD_W = HALF_W + TPS_W;
  localparam int QUO_W   = VEL_W - 1;
  localparam int HI_W    = PROD_W - QUO_W;
  localparam int CNT_W   = $clog2(QUO_W);

  localparam int IN_W  = ((RAW_W + TIMER_W + 7) / 8) * 8;
  localparam int OUT_W = ((ANGLE_W + VEL_W + 7) / 8) * 8;

  localparam logic [TPS_W-1:0] TPS_C = TPS_W'(TICKS_PER_SECOND);
  localparam logic [QUO_W-1:0] VEL_LIMIT =
    QUO_W'(64'(COUNTS_PER_TURN) * 64'(TICKS_PER_SECOND));

  localparam logic [CFG_IDX_W-1:0] REG_WRAP_THR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_INT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FB_INT   = 2'd2;

  typedef struct packed {
    logic [MAG_W-1:0]   mag;
    logic               neg;
    logic [TIMER_W-1:0] interval;
  } vel_req_t;

endpackage

FILE: rtl/mavt_vel_unit.sv
// ----------------------------------------------------------------------------
// Velocity unit
// Multiplies the angle change by the tick rate with one shared multiplier in
// two halves, then divides by the interval with a radix-2 restoring divider,
// saturating the quotient at the velocity limit.
// ----------------------------------------------------------------------------
module mavt_vel_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  mavt_pkg::vel_req_t           req,
  output logic                         done,
  output logic [mavt_pkg::VEL_W-1:0]   velocity
);

  localparam logic [2:0] U_IDLE = 3'd0;
  localparam logic [2:0] U_MLO  = 3'd1;
  localparam logic [2:0] U_MHI  = 3'd2;
  localparam logic [2:0] U_ADD  = 3'd3;
  localparam logic [2:0] U_CHK  = 3'd4;
  localparam logic [2:0] U_DIV  = 3'd5;
  localparam logic [2:0] U_FIN  = 3'd6;

  logic [2:0]                      ust_r, ust_nxt;
  logic                            done_r, done_nxt;
  logic [mavt_pkg::MAG_W-1:0]      mag_r, mag_nxt;
  logic                            neg_r, neg_nxt;
  logic [mavt_pkg::TIMER_W-1:0]    e_r, e_nxt;
  logic [mavt_pkg::PPROD_W-1:0]    prod_r, prod_nxt;
  logic [mavt_pkg::PROD_W-1:0]     acc_r, acc_nxt;
  logic [mavt_pkg::TIMER_W-1:0]    rem_r, rem_nxt;
  logic [mavt_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            sat_r, sat_nxt;
  logic [mavt_pkg::VEL_W-1:0]      vel_r, vel_nxt;

  logic [mavt_pkg::HALF_W-1:0]     mul_a;
  logic [mavt_pkg::PPROD_W-1:0]    mul_p;
  logic [mavt_pkg::TIMER_W:0]      trial;
  logic [mavt_pkg::TIMER_W:0]      diff;
  logic                            ge;
  logic [mavt_pkg::QUO_W-1:0]      vmag;
  logic [mavt_pkg::VEL_W-1:0]      vel_pos;

  always_comb begin
    ust_nxt  = ust_r;
    done_nxt = 1'b0;
    mag_nxt  = mag_r;
    neg_nxt  = neg_r;
    e_nxt    = e_r;
    prod_nxt = prod_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    sat_nxt  = sat_r;
    vel_nxt  = vel_r;

    mul_a = (ust_r == U_MHI) ? mag_r[mavt_pkg::MAG_W-1:mavt_pkg::HALF_W]
                             : mag_r[mavt_pkg::HALF_W-1:0];
    mul_p = mavt_pkg::PPROD_W'(mul_a) * mavt_pkg::PPROD_W'(mavt_pkg::TPS_C);

    trial = {rem_r, acc_r[mavt_pkg::QUO_W-1]};
    ge    = trial >= {1'b0, e_r};
    diff  = trial - {1'b0, e_r};

    vmag    = (sat_r || (acc_r[mavt_pkg::QUO_W-1:0] > mavt_pkg::VEL_LIMIT)) ?
              mavt_pkg::VEL_LIMIT : acc_r[mavt_pkg::QUO_W-1:0];
    vel_pos = {1'b0, vmag};

    case (ust_r)
      U_IDLE: begin
        if (start) begin
          mag_nxt = req.mag;
          neg_nxt = req.neg;
          e_nxt   = req.interval;
          ust_nxt = U_MLO;
        end
      end
      U_MLO: begin
        prod_nxt = mul_p;
        ust_nxt  = U_MHI;
      end
      U_MHI: begin
        acc_nxt  = mavt_pkg::PROD_W'(prod_r);
        prod_nxt = mul_p;
        ust_nxt  = U_ADD;
      end
      U_ADD: begin
        acc_nxt = acc_r + {prod_r, mavt_pkg::HALF_W'(0)};
        ust_nxt = U_CHK;
      end
      U_CHK: begin
        sat_nxt = acc_r[mavt_pkg::PROD_W-1:mavt_pkg::QUO_W] >= mavt_pkg::HI_W'(e_r);
        rem_nxt = acc_r[mavt_pkg::QUO_W+mavt_pkg::TIMER_W-1:mavt_pkg::QUO_W];
        cnt_nxt = '0;
        ust_nxt = sat_nxt ? U_FIN : U_DIV;
      end
      U_DIV: begin
        rem_nxt = ge ? diff[mavt_pkg::TIMER_W-1:0] : trial[mavt_pkg::TIMER_W-1:0];
        acc_nxt[mavt_pkg::QUO_W-1:0] = {acc_r[mavt_pkg::QUO_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == mavt_pkg::CNT_W'(mavt_pkg::QUO_W - 1)) begin
          ust_nxt = U_FIN;
        end
      end
      U_FIN: begin
        vel_nxt  = neg_r ? (~vel_pos + 1'b1) : vel_pos;
        done_nxt = 1'b1;
        ust_nxt  = U_IDLE;
      end
      default: begin
        ust_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r  <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      ust_r  <= ust_nxt;
      done_r <= done_nxt;
    end
    mag_r  <= mag_nxt;
    neg_r  <= neg_nxt;
    e_r    <= e_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
    sat_r  <= sat_nxt;
    vel_r  <= vel_nxt;
  end

  assign done     = done_r;
  assign velocity = vel_r;

endmodule

FILE: rtl/multiturn_angle_velocity_tracker_top.sv
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker
// Unwraps a 12-bit absolute angle into a signed multi-turn angle and derives
// the velocity in counts per second from a down-counting tick timer.
// ----------------------------------------------------------------------------
// Each input beat carries one angle sample and one timer reading; each one
// produces exactly one output beat with the multi-turn angle, the velocity
// and a flag that is set when the fallback interval was used.
// The block handles one beat at a time: in_tready is high only while idle.
// A regular beat runs through the 36-step radix-2 restoring divider; a
// velocity that saturates skips the divider.
// The first beat after reset only primes the previous raw angle and is
// answered with the raw angle and zero velocity.
// The output register holds a finished result while out_tready is low; the
// block may accept and work on the next beat meanwhile and waits only to
// hand over its own result.
// A synchronous low rst_n clears the turn count, history and out_tvalid and
// restores the configuration defaults; cfg_we writes are taken at any edge.
// ----------------------------------------------------------------------------
module multiturn_angle_velocity_tracker_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // raw_angle[11:0], timer_value[35:12], zero pad
  input  logic [mavt_pkg::IN_W-1:0]        in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // full_angle[43:0], velocity[80:44], zero pad
  output logic [mavt_pkg::OUT_W-1:0]       out_tdata,
  // interval_fallback[0]
  output logic [0:0]                       out_tuser,
  input  logic                             cfg_we,
  input  logic [mavt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mavt_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_TURN = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_VEL  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]                        st_r, st_nxt;
  logic [mavt_pkg::RAW_W-1:0]        raw_r, raw_nxt;
  logic [mavt_pkg::TIMER_W-1:0]      timer_r, timer_nxt;
  logic [mavt_pkg::RAW_W-1:0]        wthr_r, wthr_nxt;
  logic [mavt_pkg::TIMER_W-1:0]      maxi_r, maxi_nxt;
  logic [mavt_pkg::TIMER_W-1:0]      fbi_r, fbi_nxt;
  logic [mavt_pkg::TURN_W-1:0]       turn_r, turn_nxt;
  logic [mavt_pkg::RAW_W-1:0]        prev_raw_r, prev_raw_nxt;
  logic                              primed_r, primed_nxt;
  logic [mavt_pkg::ANGLE_W-1:0]      prev_full_r, prev_full_nxt;
  logic [mavt_pkg::TIMER_W-1:0]      prev_timer_r, prev_timer_nxt;
  logic [mavt_pkg::ANGLE_W-1:0]      full_r, full_nxt;
  logic                              fb_r, fb_nxt;
  logic                              prime_r, prime_nxt;
  logic                              out_tvalid_r, out_tvalid_nxt;
  logic [mavt_pkg::ANGLE_W-1:0]      out_full_r, out_full_nxt;
  logic [mavt_pkg::VEL_W-1:0]        out_vel_r, out_vel_nxt;
  logic                              out_fb_r, out_fb_nxt;

  logic [mavt_pkg::RAW_W:0]          dd;
  logic [mavt_pkg::RAW_W:0]          dd_neg;
  logic [mavt_pkg::RAW_W-1:0]        absd;
  logic [mavt_pkg::RAW_W-1:0]        thr;
  logic [mavt_pkg::TURN_W-1:0]       turn_upd;
  logic                              t_ge;
  logic [mavt_pkg::TIMER_W-1:0]      elapsed;
  logic                              refuse;
  logic [mavt_pkg::TIMER_W-1:0]      fb_int;
  logic [mavt_pkg::ANGLE_W:0]        delta;
  logic [mavt_pkg::ANGLE_W:0]        dmag;
  mavt_pkg::vel_req_t                req;
  logic                              vel_start;
  logic                              vel_done;
  logic [mavt_pkg::VEL_W-1:0]        vel_res;

  // Turn tracking.
  always_comb begin
    dd     = {1'b0, raw_r} - {1'b0, prev_raw_r};
    dd_neg = ~dd + 1'b1;
    absd   = dd[mavt_pkg::RAW_W] ? dd_neg[mavt_pkg::RAW_W-1:0] : dd[mavt_pkg::RAW_W-1:0];
    thr    = (wthr_r == '0) ? mavt_pkg::RAW_W'(1) : wthr_r;
    if (absd >= thr) begin
      turn_upd = dd[mavt_pkg::RAW_W] ? (turn_r + 1'b1) : (turn_r - 1'b1);
    end else begin
      turn_upd = turn_r;
    end
  end

  // Elapsed ticks and angle change.
  always_comb begin
    t_ge    = timer_r >= prev_timer_r;
    elapsed = prev_timer_r - timer_r - mavt_pkg::TIMER_W'(t_ge);
    refuse  = (elapsed == '0) || (elapsed > maxi_r);
    fb_int  = (fbi_r == '0) ? mavt_pkg::TIMER_W'(1) : fbi_r;
    delta   = {full_r[mavt_pkg::ANGLE_W-1], full_r}
            - {prev_full_r[mavt_pkg::ANGLE_W-1], prev_full_r};
    dmag    = delta[mavt_pkg::ANGLE_W] ? (~delta + 1'b1) : delta;
    req.mag      = dmag[mavt_pkg::ANGLE_W-1:0];
    req.neg      = delta[mavt_pkg::ANGLE_W];
    req.interval = refuse ? fb_int : elapsed;
  end

  assign vel_start = (st_r == S_PREP);

  mavt_vel_unit u_vel (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (vel_start),
    .req      (req),
    .done     (vel_done),
    .velocity (vel_res)
  );

  always_comb begin
    st_nxt         = st_r;
    raw_nxt        = raw_r;
    timer_nxt      = timer_r;
    wthr_nxt       = wthr_r;
    maxi_nxt       = maxi_r;
    fbi_nxt        = fbi_r;
    turn_nxt       = turn_r;
    prev_raw_nxt   = prev_raw_r;
    primed_nxt     = primed_r;
    prev_full_nxt  = prev_full_r;
    prev_timer_nxt = prev_timer_r;
    full_nxt       = full_r;
    fb_nxt         = fb_r;
    prime_nxt      = prime_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_full_nxt   = out_full_r;
    out_vel_nxt    = out_vel_r;
    out_fb_nxt     = out_fb_r;

    if (cfg_we) begin
      case (cfg_index)
        mavt_pkg::REG_WRAP_THR: wthr_nxt = cfg_wdata[mavt_pkg::RAW_W-1:0];
        mavt_pkg::REG_MAX_INT:  maxi_nxt = cfg_wdata[mavt_pkg::TIMER_W-1:0];
        mavt_pkg::REG_FB_INT:   fbi_nxt  = cfg_wdata[mavt_pkg::TIMER_W-1:0];
        default: begin
        end
      endcase
    end

    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          raw_nxt   = in_tdata[mavt_pkg::RAW_W-1:0];
          timer_nxt = in_tdata[mavt_pkg::RAW_W+mavt_pkg::TIMER_W-1:mavt_pkg::RAW_W];
          st_nxt    = S_TURN;
        end
      end
      S_TURN: begin
        prev_raw_nxt = raw_r;
        if (!primed_r) begin
          primed_nxt = 1'b1;
          full_nxt   = mavt_pkg::ANGLE_W'(raw_r);
          fb_nxt     = 1'b0;
          prime_nxt  = 1'b1;
          st_nxt     = S_OUT;
        end else begin
          turn_nxt  = turn_upd;
          full_nxt  = {turn_upd, raw_r};
          prime_nxt = 1'b0;
          st_nxt    = S_PREP;
        end
      end
      S_PREP: begin
        fb_nxt         = refuse;
        prev_full_nxt  = full_r;
        prev_timer_nxt = timer_r;
        st_nxt         = S_VEL;
      end
      S_VEL: begin
        if (vel_done) begin
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_full_nxt   = full_r;
          out_vel_nxt    = prime_r ? '0 : vel_res;
          out_fb_nxt     = fb_r;
          st_nxt         = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      wthr_r       <= 12'd3277;
      maxi_r       <= 24'd4500000;
      fbi_r        <= 24'd9000;
      turn_r       <= '0;
      prev_raw_r   <= '0;
      primed_r     <= 1'b0;
      prev_full_r  <= '0;
      prev_timer_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      wthr_r       <= wthr_nxt;
      maxi_r       <= maxi_nxt;
      fbi_r        <= fbi_nxt;
      turn_r       <= turn_nxt;
      prev_raw_r   <= prev_raw_nxt;
      primed_r     <= primed_nxt;
      prev_full_r  <= prev_full_nxt;
      prev_timer_r <= prev_timer_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    raw_r      <= raw_nxt;
    timer_r    <= timer_nxt;
    full_r     <= full_nxt;
    fb_r       <= fb_nxt;
    prime_r    <= prime_nxt;
    out_full_r <= out_full_nxt;
    out_vel_r  <= out_vel_nxt;
    out_fb_r   <= out_fb_nxt;
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {(mavt_pkg::OUT_W - mavt_pkg::ANGLE_W - mavt_pkg::VEL_W)'(0),
                       out_vel_r, out_full_r};
  assign out_tuser  = out_fb_r;

endmodule

FILE: rtl/mavt_checker.sv
// ----------------------------------------------------------------------------
// Multi-turn angle and velocity tracker checker
// Port-level properties of the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "multiturn_angle_velocity_tracker_top_assert.svh"

module mavt_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [mavt_pkg::OUT_W-1:0]   out_tdata
);

  logic signed [mavt_pkg::VEL_W-1:0] vel;
  logic signed [mavt_pkg::VEL_W-1:0] lim;

  assign vel = out_tdata[mavt_pkg::ANGLE_W+mavt_pkg::VEL_W-1:mavt_pkg::ANGLE_W];
  assign lim = {1'b0, mavt_pkg::VEL_LIMIT};

  `MAVT_ASSERT_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "output beat changed while stalled")
  `MAVT_ASSERT_IMP(a_out_drop, $fell(out_tvalid) && $past(rst_n), $past(out_tready), "output beat dropped without a handshake")
  `MAVT_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "input taken while a beat is in progress")
  `MAVT_ASSERT_IMP(a_vel_limit, out_tvalid, (vel <= lim) && (vel >= -lim), "velocity outside the saturation limit")

endmodule

bind multiturn_angle_velocity_tracker_top mavt_checker u_mavt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
